>>> rtl/core/cvp_pkg.sv
// ----------------------------------------------------------------------------
// cvp_pkg
// Shared types and constants of the 2D camera view-projection pipeline.
// ----------------------------------------------------------------------------
package cvp_pkg;

   // Q30 fixed-point constants
   localparam logic [30:0] Q30_ONE     = 31'h4000_0000;
   localparam logic [60:0] Q30_HALF    = 61'h2000_0000;
   localparam logic [30:0] PI_HALF_Q30 = 31'd1686629713;

   // Horner divisors of the sin and cos series and their 2^32 reciprocals
   localparam int unsigned SIN_DIV [5] = '{110, 72, 42, 20, 6};
   localparam int unsigned COS_DIV [5] = '{90, 56, 30, 12, 2};
   localparam logic [31:0] SIN_RCP [5] = '{
      32'(64'd4294967296 / 64'd110), 32'(64'd4294967296 / 64'd72),
      32'(64'd4294967296 / 64'd42),  32'(64'd4294967296 / 64'd20),
      32'(64'd4294967296 / 64'd6)};
   localparam logic [31:0] COS_RCP [5] = '{
      32'(64'd4294967296 / 64'd90), 32'(64'd4294967296 / 64'd56),
      32'(64'd4294967296 / 64'd30), 32'(64'd4294967296 / 64'd12),
      32'(64'd4294967296 / 64'd2)};

   // pipeline depths
   localparam int SC_LAT    = 20;  // angle in, sin/cos out
   localparam int PROD_LAT  = 2;   // products, numerator sums
   localparam int DIV_QBITS = 34;  // quotient bits before rounding
   localparam int DIV_LAT   = DIV_QBITS + 3;

   localparam logic [31:0] POS_LIMIT = 32'h7FFF_FFFF;
   localparam logic [31:0] NEG_LIMIT = 32'h8000_0000;

   typedef struct packed {
      logic signed [31:0] s;
      logic signed [31:0] c;
   } sc_type;

endpackage

>>> rtl/core/cvp_if.sv
// ----------------------------------------------------------------------------
// cvp_if
// Request and response channels of the camera view-projection block.
// ----------------------------------------------------------------------------
interface cvp_req_if #(parameter int ANGLE_BITS = 16);
   logic                  valid;
   logic                  ready;
   logic signed [31:0]    pos_x;
   logic signed [31:0]    pos_y;
   logic [31:0]           rect_width;
   logic [31:0]           rect_height;
   logic [ANGLE_BITS-1:0] angle;

   modport source (output valid, pos_x, pos_y, rect_width, rect_height, angle,
                   input ready);
   modport sink   (input valid, pos_x, pos_y, rect_width, rect_height, angle,
                   output ready);
endinterface

interface cvp_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] m00;
   logic signed [31:0] m01;
   logic signed [31:0] m02;
   logic signed [31:0] m10;
   logic signed [31:0] m11;
   logic signed [31:0] m12;
   logic               size_error;
   logic               saturated;

   modport source (output valid, m00, m01, m02, m10, m11, m12, size_error, saturated,
                   input ready);
   modport sink   (input valid, m00, m01, m02, m10, m11, m12, size_error, saturated,
                   output ready);
endinterface

>>> rtl/core/camera_view_projection_2d.sv
// ----------------------------------------------------------------------------
// camera_view_projection_2d
// Request to response: sin/cos, products, then one-bit-per-stage division.
// Throughput: one item per cycle unless stalled; the dividers set the depth.
// A stalled response freezes the whole pipeline; nothing is dropped.
// Reset clears the valid line only; no clearing pass.
// ----------------------------------------------------------------------------
module camera_view_projection_2d #(
   parameter int ANGLE_BITS = 16,
   parameter int FRAC_BITS  = 16
) (
   input  logic        clock,
   input  logic        reset,
   cvp_req_if.sink     req_ch,
   cvp_rsp_if.source   rsp_ch
);

   localparam int SCL = cvp_pkg::SC_LAT;
   localparam int WHL = cvp_pkg::SC_LAT + cvp_pkg::PROD_LAT;
   localparam int LAT = WHL + cvp_pkg::DIV_LAT;

   logic           adv;
   logic [LAT-1:0] vld_ff, vld_in;
   logic [LAT-1:0] err_ff;

   logic signed [31:0] px_ff [SCL];
   logic signed [31:0] py_ff [SCL];
   logic [31:0]        w_ff  [WHL];
   logic [31:0]        h_ff  [WHL];

   cvp_pkg::sc_type    sc;
   logic signed [63:0] c64, s64, px64, py64;
   logic signed [63:0] cpx_ff, spy_ff, spx_ff, cpy_ff;
   logic signed [63:0] c1_ff, s1_ff, px1_ff, py1_ff;
   logic signed [63:0] n_ff [6];
   logic signed [31:0] q    [6];
   logic [5:0]         sat;

   // the whole pipeline moves unless the output holds an untaken item
   assign adv    = !vld_ff[LAT-1] || rsp_ch.ready;
   assign vld_in = {vld_ff[LAT-2:0], req_ch.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   // operand delay lines
   always_ff @(posedge clock) begin
      if (adv) begin
         err_ff <= {err_ff[LAT-2:0],
                    (req_ch.rect_width == 32'd0) || (req_ch.rect_height == 32'd0)};
         px_ff[0] <= req_ch.pos_x;
         py_ff[0] <= req_ch.pos_y;
         for (int i = 1; i < SCL; i++) begin
            px_ff[i] <= px_ff[i-1];
            py_ff[i] <= py_ff[i-1];
         end
         w_ff[0] <= req_ch.rect_width;
         h_ff[0] <= req_ch.rect_height;
         for (int i = 1; i < WHL; i++) begin
            w_ff[i] <= w_ff[i-1];
            h_ff[i] <= h_ff[i-1];
         end
      end
   end

   cvp_sincos #(.ANGLE_BITS (ANGLE_BITS)) u_sincos (
      .clock (clock),
      .en    (adv),
      .angle (req_ch.angle),
      .sc    (sc)
   );

   assign c64  = {{32{sc.c[31]}}, sc.c};
   assign s64  = {{32{sc.s[31]}}, sc.s};
   assign px64 = {{32{px_ff[SCL-1][31]}}, px_ff[SCL-1]};
   assign py64 = {{32{py_ff[SCL-1][31]}}, py_ff[SCL-1]};

   // products, then numerators
   always_ff @(posedge clock) begin
      if (adv) begin
         cpx_ff <= c64 * px64;
         spy_ff <= s64 * py64;
         spx_ff <= s64 * px64;
         cpy_ff <= c64 * py64;
         c1_ff  <= c64;
         s1_ff  <= s64;
         px1_ff <= px64;
         py1_ff <= py64;
         n_ff[0] <= c1_ff <<< FRAC_BITS;
         n_ff[1] <= s1_ff <<< FRAC_BITS;
         n_ff[2] <= -(cpx_ff + spy_ff + (px1_ff <<< 30));
         n_ff[3] <= -(s1_ff <<< FRAC_BITS);
         n_ff[4] <= c1_ff <<< FRAC_BITS;
         n_ff[5] <= spx_ff - cpy_ff - (py1_ff <<< 30);
      end
   end

   // row 0 over width, row 1 over height
   for (genvar k = 0; k < 6; k++) begin : g_div
      cvp_entry_div #(.FRAC_BITS (FRAC_BITS)) u_div (
         .clock (clock),
         .en    (adv),
         .num   (n_ff[k]),
         .den   ((k < 3) ? w_ff[WHL-1] : h_ff[WHL-1]),
         .quo   (q[k]),
         .sat   (sat[k])
      );
   end

   assign req_ch.ready      = adv;
   assign rsp_ch.valid      = vld_ff[LAT-1];
   assign rsp_ch.size_error = err_ff[LAT-1];
   assign rsp_ch.saturated  = !err_ff[LAT-1] && (|sat);
   assign rsp_ch.m00 = err_ff[LAT-1] ? '0 : q[0];
   assign rsp_ch.m01 = err_ff[LAT-1] ? '0 : q[1];
   assign rsp_ch.m02 = err_ff[LAT-1] ? '0 : q[2];
   assign rsp_ch.m10 = err_ff[LAT-1] ? '0 : q[3];
   assign rsp_ch.m11 = err_ff[LAT-1] ? '0 : q[4];
   assign rsp_ch.m12 = err_ff[LAT-1] ? '0 : q[5];

`ifndef NO_ASSERTIONS
   // a held response blocks new requests
   a_hold_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.ready |-> !req_ch.ready)
      else $error("request taken while response stalled");

   // an accepted item enters the first stage
   a_enter: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> vld_ff[0])
      else $error("accepted item lost at entry");

   // a stall freezes the valid line
   a_freeze: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(vld_ff))
      else $error("valid line moved during stall");

   // size error forces zero entries and no saturation
   a_size_err: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.size_error |->
         rsp_ch.m00 == 32'sd0 && rsp_ch.m12 == 32'sd0 && !rsp_ch.saturated)
      else $error("size error with nonzero entries");
`endif

endmodule

>>> rtl/core/cvp_poly_step.sv
// ----------------------------------------------------------------------------
// cvp_poly_step
// One Horner step p' = 1 - round(t*p)/DIVISOR in Q30, over three stages.
// ----------------------------------------------------------------------------
module cvp_poly_step #(
   parameter int unsigned DIVISOR = 2,
   parameter logic [31:0] RECIP   = 32'h8000_0000
) (
   input  logic        clock,
   input  logic        en,
   input  logic [29:0] t_in,
   input  logic [30:0] p_in,
   output logic [29:0] t_out,
   output logic [30:0] p_out
);

   logic [29:0] m_a_ff, t_a_ff;
   logic [29:0] m_b_ff, q0_b_ff, t_b_ff;
   logic [30:0] p_c_ff;
   logic [29:0] t_c_ff;

   logic [60:0] mp;
   logic [61:0] qr;
   logic [36:0] qd;
   logic [29:0] rem;
   logic [29:0] quo;

   // rounded Q30 product
   assign mp = 61'(t_in) * 61'(p_in) + cvp_pkg::Q30_HALF;
   // quotient estimate, low by at most one
   assign qr = 62'(m_a_ff) * 62'(RECIP);
   // one correction step
   assign qd  = 37'(q0_b_ff) * 37'(DIVISOR);
   assign rem = m_b_ff - qd[29:0];
   assign quo = (rem >= 30'(DIVISOR)) ? q0_b_ff + 30'd1 : q0_b_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         m_a_ff  <= mp[59:30];
         t_a_ff  <= t_in;
         q0_b_ff <= qr[61:32];
         m_b_ff  <= m_a_ff;
         t_b_ff  <= t_a_ff;
         p_c_ff  <= cvp_pkg::Q30_ONE - 31'(quo);
         t_c_ff  <= t_b_ff;
      end
   end

   assign t_out = t_c_ff;
   assign p_out = p_c_ff;

endmodule

>>> rtl/core/cvp_sincos.sv
// ----------------------------------------------------------------------------
// cvp_sincos
// Binary angle to signed Q30 sin and cos: octant reduction, series in two
// parallel Horner lanes, quadrant fix-up. Twenty stages.
// ----------------------------------------------------------------------------
module cvp_sincos #(
   parameter int ANGLE_BITS = 16
) (
   input  logic                  clock,
   input  logic                  en,
   input  logic [ANGLE_BITS-1:0] angle,
   output cvp_pkg::sc_type       sc
);

   localparam int CTL_LEN = 19;

   logic [31:0] u;
   logic [29:0] r;
   logic        swap;

   logic [29:0] rr0_ff;
   logic [1:0]  quad_ff [CTL_LEN];
   logic        swap_ff [CTL_LEN];
   logic [29:0] x_ff [1:17];
   logic [29:0] t2_ff;
   logic [30:0] s0_ff, c0_ff;
   cvp_pkg::sc_type sc_ff;

   logic [60:0] xp, tp, sp;
   logic [29:0] t_sin [6];
   logic [30:0] p_sin [6];
   logic [29:0] t_cos [6];
   logic [30:0] p_cos [6];
   logic signed [31:0] sv, cv;

   // fold the angle into the first eighth of a turn
   assign u    = 32'(angle) << (32 - ANGLE_BITS);
   assign r    = u[29:0];
   assign swap = r > 30'h2000_0000;

   assign xp = 61'(rr0_ff) * 61'(cvp_pkg::PI_HALF_Q30) + cvp_pkg::Q30_HALF;
   assign tp = 61'(x_ff[1]) * 61'(x_ff[1]) + cvp_pkg::Q30_HALF;
   assign sp = 61'(x_ff[17]) * 61'(p_sin[5]) + cvp_pkg::Q30_HALF;

   always_ff @(posedge clock) begin
      if (en) begin
         rr0_ff     <= swap ? 30'(31'h4000_0000 - 31'(r)) : r;
         quad_ff[0] <= u[31:30];
         swap_ff[0] <= swap;
         for (int i = 1; i < CTL_LEN; i++) begin
            quad_ff[i] <= quad_ff[i-1];
            swap_ff[i] <= swap_ff[i-1];
         end
         x_ff[1] <= xp[59:30];
         for (int i = 2; i <= 17; i++) begin
            x_ff[i] <= x_ff[i-1];
         end
         t2_ff <= tp[59:30];
         s0_ff <= sp[60:30];
         c0_ff <= p_cos[5];
         sc_ff <= '{s: sv, c: cv};
      end
   end

   // Horner lanes
   assign t_sin[0] = t2_ff;
   assign p_sin[0] = cvp_pkg::Q30_ONE;
   assign t_cos[0] = t2_ff;
   assign p_cos[0] = cvp_pkg::Q30_ONE;

   for (genvar k = 0; k < 5; k++) begin : g_step
      cvp_poly_step #(
         .DIVISOR (cvp_pkg::SIN_DIV[k]),
         .RECIP   (cvp_pkg::SIN_RCP[k])
      ) u_sin (
         .clock (clock), .en (en),
         .t_in  (t_sin[k]), .p_in (p_sin[k]),
         .t_out (t_sin[k+1]), .p_out (p_sin[k+1])
      );
      cvp_poly_step #(
         .DIVISOR (cvp_pkg::COS_DIV[k]),
         .RECIP   (cvp_pkg::COS_RCP[k])
      ) u_cos (
         .clock (clock), .en (en),
         .t_in  (t_cos[k]), .p_in (p_cos[k]),
         .t_out (t_cos[k+1]), .p_out (p_cos[k+1])
      );
   end

   // undo the reflection and quadrant
   always_comb begin
      logic signed [31:0] so, co;
      so = swap_ff[18] ? $signed({1'b0, c0_ff}) : $signed({1'b0, s0_ff});
      co = swap_ff[18] ? $signed({1'b0, s0_ff}) : $signed({1'b0, c0_ff});
      case (quad_ff[18])
         2'd0: begin cv = co;  sv = so;  end
         2'd1: begin cv = -so; sv = co;  end
         2'd2: begin cv = -co; sv = -so; end
         default: begin cv = so; sv = -co; end
      endcase
   end

   assign sc = sc_ff;

endmodule

>>> rtl/core/cvp_entry_div.sv
// ----------------------------------------------------------------------------
// cvp_entry_div
// Signed numerator over width/height: one restoring quotient bit per stage,
// round half away from zero, clamp to 32 bits. DIV_LAT stages.
// ----------------------------------------------------------------------------
module cvp_entry_div #(
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               en,
   input  logic signed [63:0] num,
   input  logic [31:0]        den,
   output logic signed [31:0] quo,
   output logic               sat
);

   localparam int QB = cvp_pkg::DIV_QBITS;

   logic [63:0] neg_num;
   logic [62:0] msh;

   logic        neg0_ff;
   logic [62:0] mag0_ff;
   logic [31:0] d0_ff;

   logic [31:0]   rem_ff  [QB+1];
   logic [QB-1:0] lo_ff   [QB+1];
   logic [QB-1:0] q_ff    [QB+1];
   logic [31:0]   d_ff    [QB+1];
   logic          neg_ff  [QB+1];
   logic          ovf_ff  [QB+1];

   logic signed [31:0] quo_ff;
   logic               sat_ff;

   logic [QB:0]   rnd_w;
   logic [QB-1:0] rnd;
   logic          over;

   assign neg_num = -num;
   assign msh     = mag0_ff >> (28 - FRAC_BITS);

   // sign split, then prescale and overflow check
   always_ff @(posedge clock) begin
      if (en) begin
         neg0_ff   <= num[63];
         mag0_ff   <= num[63] ? neg_num[62:0] : num[62:0];
         d0_ff     <= den;
         ovf_ff[0] <= {3'd0, msh[62:QB]} >= d0_ff;
         rem_ff[0] <= 32'(msh[62:QB]);
         lo_ff[0]  <= msh[QB-1:0];
         q_ff[0]   <= '0;
         d_ff[0]   <= d0_ff;
         neg_ff[0] <= neg0_ff;
      end
   end

   // restoring division stages
   for (genvar i = 0; i < QB; i++) begin : g_bit
      logic [32:0] trial;
      logic        ge;
      logic [32:0] diff;
      assign trial = {rem_ff[i], lo_ff[i][QB-1]};
      assign ge    = trial >= {1'b0, d_ff[i]};
      assign diff  = trial - {1'b0, d_ff[i]};
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[i+1] <= ge ? diff[31:0] : trial[31:0];
            lo_ff[i+1]  <= lo_ff[i] << 1;
            q_ff[i+1]   <= {q_ff[i][QB-2:0], ge};
            d_ff[i+1]   <= d_ff[i];
            neg_ff[i+1] <= neg_ff[i];
            ovf_ff[i+1] <= ovf_ff[i];
         end
      end
   end

   // round on the extra quotient bit, then clamp
   assign rnd_w = ({1'b0, q_ff[QB]} + {{QB{1'b0}}, 1'b1}) >> 1;
   assign rnd   = rnd_w[QB-1:0];
   assign over  = ovf_ff[QB] ||
                  (neg_ff[QB] ? rnd > QB'(cvp_pkg::NEG_LIMIT)
                              : rnd > QB'(cvp_pkg::POS_LIMIT));

   always_ff @(posedge clock) begin
      if (en) begin
         sat_ff <= over;
         if (over) begin
            quo_ff <= neg_ff[QB] ? cvp_pkg::NEG_LIMIT : cvp_pkg::POS_LIMIT;
         end else begin
            quo_ff <= neg_ff[QB] ? -rnd[31:0] : rnd[31:0];
         end
      end
   end

   assign quo = quo_ff;
   assign sat = sat_ff;

endmodule
